>>> hw/rtl/fpfa_pkg.sv
`timescale 1ns / 1ps

package fpfa_pkg;

  // Default sizing of the block table
  localparam int DEF_MAX_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;

  // Fixed field widths on the ports
  localparam int KIND_W   = 2;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int BLK_W    = 4;
  localparam int REM_W    = 16;
  localparam int POLICY_W = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // Placement policies; the unused code falls back to first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    block_number;
    logic [REM_W-1:0]    remaining;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // take the input item
    logic scan;      // issue one table read and advance the scan pointer
    logic finish;    // close out an allocate or restore
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last; // this scan step is the final one
  } dp_stat_t;

endpackage

>>> hw/rtl/fixed_partition_fit_allocator_unit.sv
`timescale 1ns / 1ps

// Fixed-partition block allocator with first, worst and best fit placement.
// Request channel (req_valid/req_ready, payload req): kind 0 appends a block
// of the given size, kind 1 allocates the given size from one block, kind 2
// copies every original size back into its remaining size. Each transaction
// yields exactly one response transaction on rsp_valid/rsp_ready.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the placement
// policy and is always ready; the user must see that it is written only while
// the block is idle, which the block itself does not enforce. Load and unused
// kinds go from acceptance through the done state to the output register.
// Allocate and restore walk the table one entry per cycle through the single
// read port of the size memories, then pass the drain, write and done states;
// the block is back in idle for the next request as its response appears.
// The response sits in an output register: while the receiver stalls, the
// next request is still processed up to the done state and waits there.
// Reset clears the block count, the policy (first fit) and the response
// valid; the tables themselves are not cleared and need no clearing pass.
module fixed_partition_fit_allocator_unit #(
  parameter int MAX_BLOCKS = fpfa_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = fpfa_pkg::DEF_SIZE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  fpfa_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output fpfa_pkg::rsp_t                  rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpfa_pkg::POLICY_W-1:0]   cfg_data
);

  logic [fpfa_pkg::POLICY_W-1:0] fit_policy;
  fpfa_pkg::ctrl_cmd_t           cmd;
  fpfa_pkg::dp_stat_t            stat;

  // Policy register: writes land at once, no backpressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= fpfa_pkg::POL_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      fit_policy <= cfg_data;
    end
  end

  // Sequencer: idle, scan the table, drain the read pipe, commit, hand off
  fpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Size tables, candidate tracking and the response register
  fpfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .fit_policy (fit_policy),
    .cmd        (cmd),
    .stat       (stat),
    .rsp        (rsp)
  );

  // One request in flight: after acceptance the block leaves idle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == fpfa_pkg::STAT_OK ||
                   rsp.status == fpfa_pkg::STAT_NOFIT ||
                   rsp.status == fpfa_pkg::STAT_FULL))
    else $error("illegal response status");

  // Misses and full-table loads carry no block information
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != fpfa_pkg::STAT_OK) |->
      (rsp.block_number == '0 && rsp.remaining == '0))
    else $error("failed response carries block data");

endmodule

>>> hw/rtl/fpfa_ctrl.sv
`timescale 1ns / 1ps

module fpfa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [fpfa_pkg::KIND_W-1:0]   req_kind,
  output logic                          req_ready,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output fpfa_pkg::ctrl_cmd_t           cmd,
  input  fpfa_pkg::dp_stat_t            stat
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (req_kind inside {fpfa_pkg::KIND_ALLOC, fpfa_pkg::KIND_RESTORE}) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> hw/rtl/fpfa_datapath.sv
`timescale 1ns / 1ps

module fpfa_datapath #(
  parameter int MAX_BLOCKS = fpfa_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = fpfa_pkg::DEF_SIZE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fpfa_pkg::req_t                  req,
  input  logic [fpfa_pkg::POLICY_W-1:0]   fit_policy,
  input  fpfa_pkg::ctrl_cmd_t             cmd,
  output fpfa_pkg::dp_stat_t              stat,
  output fpfa_pkg::rsp_t                  rsp
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // Block tables
  logic [SIZE_BITS-1:0] rem_mem  [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] orig_mem [MAX_BLOCKS];

  logic [CW-1:0]                   count;
  logic [CW-1:0]                   addr_cnt;
  logic [fpfa_pkg::KIND_W-1:0]     kind_q;
  logic [SIZE_BITS-1:0]            size_q;
  logic [SIZE_BITS-1:0]            size_m;
  logic                            rd_en;
  logic                            rd_vld;
  logic [IW-1:0]                   rd_idx;
  logic [SIZE_BITS-1:0]            rem_rd;
  logic [SIZE_BITS-1:0]            orig_rd;
  logic                            found;
  logic [IW-1:0]                   pick;
  logic [SIZE_BITS-1:0]            best;
  logic                            take;
  logic                            load_wr;
  logic                            full;
  logic                            rem_we;
  logic [IW-1:0]                   rem_wa;
  logic [SIZE_BITS-1:0]            rem_wd;
  logic [SIZE_BITS-1:0]            shrunk;
  fpfa_pkg::rsp_t                  res;

  assign size_m  = SIZE_BITS'(req.size);
  assign full    = (count >= CW'(MAX_BLOCKS));
  assign load_wr = cmd.accept && (req.kind == fpfa_pkg::KIND_LOAD) && !full;
  assign rd_en   = cmd.scan && (addr_cnt < count);
  assign shrunk  = best - size_q;

  assign stat.scan_last = ((addr_cnt + CW'(1)) >= count);

  // Candidate selection on the registered read data
  always_comb begin
    take = 1'b0;
    if (rd_vld && (kind_q == fpfa_pkg::KIND_ALLOC) && (size_q <= rem_rd)) begin
      case (fit_policy)
        fpfa_pkg::POL_WORST: take = !found || (rem_rd > best);
        fpfa_pkg::POL_BEST:  take = !found || (rem_rd < best);
        default:             take = !found;
      endcase
    end
  end

  // One write port on the remaining-size table
  always_comb begin
    rem_we = 1'b0;
    rem_wa = count[IW-1:0];
    rem_wd = size_m;
    if (load_wr) begin
      rem_we = 1'b1;
    end else if (rd_vld && (kind_q == fpfa_pkg::KIND_RESTORE)) begin
      rem_we = 1'b1;
      rem_wa = rd_idx;
      rem_wd = orig_rd;
    end else if (cmd.finish && (kind_q == fpfa_pkg::KIND_ALLOC) && found) begin
      rem_we = 1'b1;
      rem_wa = pick;
      rem_wd = shrunk;
    end
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (load_wr) begin
      orig_mem[count[IW-1:0]] <= size_m;
    end
    if (rd_en) begin
      rem_rd  <= rem_mem[addr_cnt[IW-1:0]];
      orig_rd <= orig_mem[addr_cnt[IW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (load_wr) begin
        count <= count + CW'(1);
      end
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= req.kind;
      size_q   <= size_m;
      addr_cnt <= '0;
      case (req.kind)
        fpfa_pkg::KIND_LOAD: begin
          if (full) begin
            res <= '{fpfa_pkg::STAT_FULL, '0, '0};
          end else begin
            res <= '{fpfa_pkg::STAT_OK, fpfa_pkg::BLK_W'(count),
                     fpfa_pkg::REM_W'(size_m)};
          end
        end
        default: begin
          res <= '{fpfa_pkg::STAT_OK, '0, '0};
        end
      endcase
    end
    if (cmd.scan) begin
      addr_cnt <= addr_cnt + CW'(1);
    end
    if (rd_en) begin
      rd_idx <= addr_cnt[IW-1:0];
    end
    if (take) begin
      pick <= rd_idx;
      best <= rem_rd;
    end
    if (cmd.finish && (kind_q == fpfa_pkg::KIND_ALLOC)) begin
      if (found) begin
        res <= '{fpfa_pkg::STAT_OK, fpfa_pkg::BLK_W'(pick), fpfa_pkg::REM_W'(shrunk)};
      end else begin
        res <= '{fpfa_pkg::STAT_NOFIT, '0, '0};
      end
    end
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

endmodule

>>> tb/fixed_partition_fit_allocator_unit_tb.sv
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_unit_tb;

  localparam int TABLE_DEPTH   = fpfa_pkg::DEF_MAX_BLOCKS;
  localparam int LIMIT_CYCLES  = 200000;
  // Margin for the block to return to idle before touching the policy.
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_ITEMS  = 450;
  localparam int MAX_SHOWN     = 40;

  // Codes the block accepts but does not define.
  localparam logic [fpfa_pkg::KIND_W-1:0]   KIND_UNUSED = 2'd3;
  localparam logic [fpfa_pkg::POLICY_W-1:0] POL_UNUSED  = 2'd3;

  typedef enum int {RCV_OPEN, RCV_COIN, RCV_SPARSE, RCV_PERIODIC} rcv_mode_t;

  // Mirror of the block table: predicts one response per request transaction
  // and checks responses in order.
  class partition_scoreboard;
    logic [fpfa_pkg::SIZE_W-1:0]   remaining_tbl [TABLE_DEPTH];
    logic [fpfa_pkg::SIZE_W-1:0]   original_tbl  [TABLE_DEPTH];
    int unsigned                   loaded;
    logic [fpfa_pkg::POLICY_W-1:0] policy;
    fpfa_pkg::rsp_t                awaited_q [$];
    int unsigned                   mismatches;

    function new();
      loaded     = 0;
      policy     = fpfa_pkg::POL_FIRST;
      mismatches = 0;
      foreach (remaining_tbl[i]) begin
        remaining_tbl[i] = '0;
        original_tbl[i]  = '0;
      end
    endfunction

    function fpfa_pkg::rsp_t place(fpfa_pkg::req_t r);
      fpfa_pkg::rsp_t              res;
      int                          pick;
      bit                          found;
      logic [fpfa_pkg::SIZE_W-1:0] best;
      res   = '0;
      pick  = 0;
      found = 0;
      best  = '0;
      case (r.kind)
        fpfa_pkg::KIND_LOAD: begin
          if (loaded >= TABLE_DEPTH) begin
            res.status = fpfa_pkg::STAT_FULL;
          end else begin
            original_tbl[loaded]  = r.size;
            remaining_tbl[loaded] = r.size;
            res.block_number      = loaded[fpfa_pkg::BLK_W-1:0];
            res.remaining         = r.size;
            loaded++;
          end
        end
        fpfa_pkg::KIND_ALLOC: begin
          for (int j = 0; j < loaded; j++) begin
            if (r.size > remaining_tbl[j]) continue;
            if (policy == fpfa_pkg::POL_WORST) begin
              if (!found || remaining_tbl[j] > best) begin
                found = 1;
                pick  = j;
                best  = remaining_tbl[j];
              end
            end else if (policy == fpfa_pkg::POL_BEST) begin
              if (!found || remaining_tbl[j] < best) begin
                found = 1;
                pick  = j;
                best  = remaining_tbl[j];
              end
            end else begin
              found = 1;
              pick  = j;
              break;
            end
          end
          if (!found) begin
            res.status = fpfa_pkg::STAT_NOFIT;
          end else begin
            remaining_tbl[pick] = remaining_tbl[pick] - r.size;
            res.block_number    = pick[fpfa_pkg::BLK_W-1:0];
            res.remaining       = remaining_tbl[pick];
          end
        end
        fpfa_pkg::KIND_RESTORE: begin
          for (int j = 0; j < loaded; j++) remaining_tbl[j] = original_tbl[j];
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_request(fpfa_pkg::req_t r);
      awaited_q.push_back(place(r));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_response(fpfa_pkg::rsp_t got);
      fpfa_pkg::rsp_t want;
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("response with none awaited: status %0d block %0d rem %0d",
                                  got.status, got.block_number, got.remaining));
        return;
      end
      want = awaited_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.block_number !== want.block_number)
        report_mismatch($sformatf("block_number got %0d want %0d",
                                  got.block_number, want.block_number));
      if (got.remaining !== want.remaining)
        report_mismatch($sformatf("remaining got %0d want %0d",
                                  got.remaining, want.remaining));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_ready;
  fpfa_pkg::req_t                req;
  logic                          rsp_valid;
  logic                          rsp_ready;
  fpfa_pkg::rsp_t                rsp;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fpfa_pkg::POLICY_W-1:0] cfg_data;

  partition_scoreboard board = new();

  int unsigned cycles;
  int          burst_left;
  bit          start_hold;
  bit          hold_done;

  fixed_partition_fit_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample every handshake at the edge; the policy register follows the config
  // transaction, requests feed the predictor, responses are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.policy = cfg_data;
      if (req_valid && req_ready) board.note_request(req);
      if (rsp_valid && rsp_ready) board.check_response(rsp);
    end
  end

  // Watchdog: end the run if it has not finished by the limit.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("fixed_partition_fit_allocator_unit_tb: FAIL");
    $finish;
  end

  // Receiver: draw random stall patterns from rcv_cnt; once asked, hold off for a
  // long stretch so the output register fills and the block stalls its input.
  initial begin
    int        rcv_cnt;
    rcv_mode_t mode;
    rcv_cnt   = 0;
    mode      = RCV_OPEN;
    hold_done = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (start_hold && !hold_done) begin
        rsp_ready <= 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(posedge clk);
        hold_done = 1;
      end else begin
        if (rcv_cnt % 50 == 0) mode = rcv_mode_t'($urandom_range(0, 3));
        case (mode)
          RCV_OPEN:     rsp_ready <= 1'b1;
          RCV_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
          RCV_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
          RCV_PERIODIC: rsp_ready <= (rcv_cnt % 3 != 0);
          default:      rsp_ready <= 1'b1;
        endcase
        rcv_cnt++;
      end
    end
  end

  // Offer one request transaction and hold it until accepted. Insert a gap
  // between bursts; within a burst keep valid high across items.
  task automatic offer(input logic [fpfa_pkg::KIND_W-1:0] kind,
                       input logic [fpfa_pkg::SIZE_W-1:0] size);
    fpfa_pkg::req_t item;
    int             gap;
    item.kind = kind;
    item.size = size;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    burst_left--;
  endtask

  // Drop valid, wait for every awaited response, then let the block go idle.
  task automatic settle();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic [fpfa_pkg::POLICY_W-1:0] p);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [fpfa_pkg::SIZE_W-1:0] pick_request_size();
    int c;
    c = $urandom_range(0, 9);
    if (c < 5) return fpfa_pkg::SIZE_W'($urandom_range(0, 64));
    if (c < 8) return fpfa_pkg::SIZE_W'($urandom_range(0, 600));
    return fpfa_pkg::SIZE_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int                unsigned done_items;
    int                session;
    int                len;
    int                choice;
    logic [fpfa_pkg::POLICY_W-1:0] pol;
    start_hold = 0;
    burst_left = 0;
    done_items = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, unused kind, extreme sizes, every policy.
    offer(fpfa_pkg::KIND_ALLOC, 16'd0);          // nothing loaded: no fit
    offer(fpfa_pkg::KIND_RESTORE, 16'hFFFF);     // restore of an empty table
    offer(KIND_UNUSED, 16'hA5A5);
    offer(fpfa_pkg::KIND_LOAD, 16'hFFFF);
    offer(fpfa_pkg::KIND_LOAD, 16'd0);
    offer(fpfa_pkg::KIND_LOAD, 16'd100);
    offer(fpfa_pkg::KIND_LOAD, 16'd500);
    offer(fpfa_pkg::KIND_LOAD, 16'd200);
    offer(fpfa_pkg::KIND_ALLOC, 16'd0);          // zero request takes the first block unchanged
    offer(fpfa_pkg::KIND_ALLOC, 16'hFFFF);       // drains block 0 to zero
    offer(fpfa_pkg::KIND_ALLOC, 16'd150);
    offer(fpfa_pkg::KIND_ALLOC, 16'd600);        // no block fits
    offer(fpfa_pkg::KIND_RESTORE, 16'd0);
    settle();
    write_policy(fpfa_pkg::POL_WORST);
    offer(fpfa_pkg::KIND_ALLOC, 16'd100);
    offer(fpfa_pkg::KIND_ALLOC, 16'd0);
    settle();
    write_policy(fpfa_pkg::POL_BEST);
    offer(fpfa_pkg::KIND_ALLOC, 16'd100);        // exact fit
    offer(fpfa_pkg::KIND_ALLOC, 16'd0);          // tie between zero-size blocks: lowest wins
    settle();
    write_policy(POL_UNUSED);                    // falls back to first fit
    offer(fpfa_pkg::KIND_ALLOC, 16'd50);

    // Random sessions: each starts idle with a fresh policy, the first fills
    // the table, later ones are mostly allocations with restores between.
    session = 0;
    while (done_items < RANDOM_ITEMS) begin
      settle();
      pol = (session < 4) ? session[fpfa_pkg::POLICY_W-1:0] :
                            fpfa_pkg::POLICY_W'($urandom_range(0, 3));
      write_policy(pol);
      if (session == 1) start_hold = 1;
      if (session == 0) begin
        while (board.loaded < TABLE_DEPTH) begin
          if ($urandom_range(0, 3) == 0)
            offer(fpfa_pkg::KIND_LOAD, fpfa_pkg::SIZE_W'($urandom_range(0, 65535)));
          else
            offer(fpfa_pkg::KIND_LOAD, fpfa_pkg::SIZE_W'(16 * $urandom_range(1, 16)));
          done_items++;
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        offer(fpfa_pkg::KIND_RESTORE, fpfa_pkg::SIZE_W'($urandom_range(0, 65535)));
        done_items++;
      end
      len = $urandom_range(4, 24);
      for (int k = 0; k < len; k++) begin
        choice = $urandom_range(0, 19);
        if (choice < 14) begin
          offer(fpfa_pkg::KIND_ALLOC, pick_request_size());
        end else if (choice < 16) begin
          offer(fpfa_pkg::KIND_RESTORE, fpfa_pkg::SIZE_W'($urandom_range(0, 65535)));
        end else if (choice < 18) begin
          // table full: rejected
          offer(fpfa_pkg::KIND_LOAD, fpfa_pkg::SIZE_W'($urandom_range(0, 65535)));
        end else begin
          offer(KIND_UNUSED, fpfa_pkg::SIZE_W'($urandom_range(0, 65535)));
        end
        done_items++;
      end
      session++;
    end

    settle();
    if (board.mismatches == 0 && board.awaited_q.size() == 0) begin
      $display("fixed_partition_fit_allocator_unit_tb: PASS");
    end else begin
      $display("fixed_partition_fit_allocator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
